// ===== rtl/ypvm_pkg.sv =====
// Package for the yaw/pitch view-matrix pipeline: payload structs, format
// constants and the quarter-wave sine coefficients. No dependencies.
`default_nettype none
package ypvm_pkg;

   localparam int AngleBits   = 16;
   localparam int QBits       = AngleBits - 2;
   localparam int VecFracBits = 14;
   localparam int PolyShift   = 30 - QBits;

   localparam logic [30:0] PolyA = 31'd1686629713;
   localparam logic [30:0] PolyB = 31'd688904866;
   localparam logic [30:0] PolyC = 31'd76016977;

   localparam logic signed [17:0] VecOne = 18'sd1 <<< VecFracBits;

   typedef struct packed {
      logic [15:0]        yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [31:0] trans_right;
      logic signed [31:0] trans_up;
      logic signed [31:0] trans_fwd;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/ypvm_sin.sv =====
// Pipelined quarter-wave sine: five register stages, at most one multiply per stage.
// Depends on ypvm_pkg for the angle format and polynomial coefficients.
`default_nettype none
module ypvm_sin (
   input  wire logic                      clock,
   input  wire logic [ypvm_pkg::AngleBits-1:0] angle,
   output logic signed [17:0]             sine
);
   logic [ypvm_pkg::QBits:0] t;
   logic [30:0] x_s1_ff, x_s2_ff, x_s3_ff, x_s4_ff;
   logic [30:0] x2_s2_ff, x2_s3_ff;
   logic [30:0] t1_s3_ff, t2_s4_ff;
   logic [31:0] s_s5_ff;
   logic [5:1]  neg_ff;
   logic [61:0] p2, p3a, p3b, p4, p5;
   logic [30:0] x_in;
   logic [31:0] s_in;
   logic [17:0] mag;

   always_comb begin
      t = angle[ypvm_pkg::QBits] ?
          (({1'b1, {ypvm_pkg::QBits{1'b0}}}) - {1'b0, angle[ypvm_pkg::QBits-1:0]}) :
          {1'b0, angle[ypvm_pkg::QBits-1:0]};
      x_in = 31'(t) << ypvm_pkg::PolyShift;
      p2  = x_s1_ff * x_s1_ff;
      p3a = ypvm_pkg::PolyC * x2_s2_ff;
      p4  = x2_s3_ff * t1_s3_ff;
      p5  = x_s4_ff * t2_s4_ff;
      p3b = 62'(p3a >> 30);
      s_in = 32'(p5 >> 30);
   end

   // The sign bit travels five stages so that it meets the magnitude.
   always_ff @(posedge clock) begin
      x_s1_ff  <= x_in;
      neg_ff   <= {neg_ff[4:1], angle[ypvm_pkg::AngleBits-1]};
      x_s2_ff  <= x_s1_ff;
      x2_s2_ff <= 31'(p2 >> 30);
      x_s3_ff  <= x_s2_ff;
      x2_s3_ff <= x2_s2_ff;
      t1_s3_ff <= ypvm_pkg::PolyB - 31'(p3b);
      x_s4_ff  <= x_s3_ff;
      t2_s4_ff <= ypvm_pkg::PolyA - 31'(p4 >> 30);
      s_s5_ff  <= s_in;
   end

   always_comb begin
      logic [31:0] r;
      r = (s_s5_ff + (32'd1 << (29 - ypvm_pkg::VecFracBits))) >> (30 - ypvm_pkg::VecFracBits);
      mag = (r > 32'(ypvm_pkg::VecOne)) ? 18'(ypvm_pkg::VecOne) : r[17:0];
      sine = neg_ff[5] ? -$signed(mag) : $signed(mag);
   end
endmodule
`default_nettype wire

// ===== rtl/ypvm_basis.sv =====
// Basis stage: forward, right and up vectors from the four trig values.
// Two register stages; depends on ypvm_pkg.
`default_nettype none
module ypvm_basis (
   input  wire logic              clock,
   input  wire logic signed [17:0] sy,
   input  wire logic signed [17:0] cy,
   input  wire logic signed [17:0] sp,
   input  wire logic signed [17:0] cp,
   output logic signed [17:0]     rt_x,
   output logic signed [17:0]     rt_z,
   output logic signed [17:0]     up_x,
   output logic signed [17:0]     up_y,
   output logic signed [17:0]     up_z,
   output logic signed [17:0]     fw_x,
   output logic signed [17:0]     fw_y,
   output logic signed [17:0]     fw_z
);
   localparam int F = ypvm_pkg::VecFracBits;
   localparam logic signed [39:0] Half = 40'sd1 <<< (F - 1);

   logic signed [17:0] fx_ff, fy_ff, fz_ff, rx_ff, rz_ff;
   logic signed [17:0] fx2_ff, fy2_ff, fz2_ff, rx2_ff, rz2_ff;
   logic signed [17:0] ux_ff, uy_ff, uz_ff;
   logic signed [17:0] fx_in, fz_in, rx_in, rz_in, ux_in, uy_in, uz_in;
   logic signed [39:0] pxs, pzs, pux, puy, puz;

   function automatic logic signed [17:0] clampu(input logic signed [39:0] v);
      logic signed [39:0] r;
      r = (v + Half) >>> F;
      if (r > 40'(ypvm_pkg::VecOne)) return ypvm_pkg::VecOne;
      if (r < -40'(ypvm_pkg::VecOne)) return -ypvm_pkg::VecOne;
      return r[17:0];
   endfunction

   always_comb begin
      pxs = 40'(sy) * 40'(cp);
      pzs = 40'(cy) * 40'(cp);
      fx_in = -18'((pxs + Half) >>> F);
      fz_in = -18'((pzs + Half) >>> F);
      if (cp > 0) begin
         rx_in = cy;
         rz_in = -sy;
      end else if (cp < 0) begin
         rx_in = -cy;
         rz_in = sy;
      end else begin
         rx_in = ypvm_pkg::VecOne;
         rz_in = '0;
      end
      pux = -(40'(rz_ff) * 40'(fy_ff));
      puy = 40'(rz_ff) * 40'(fx_ff) - 40'(rx_ff) * 40'(fz_ff);
      puz = 40'(rx_ff) * 40'(fy_ff);
      ux_in = clampu(pux);
      uy_in = clampu(puy);
      uz_in = clampu(puz);
   end

   always_ff @(posedge clock) begin
      fx_ff <= fx_in;  fy_ff <= -sp;  fz_ff <= fz_in;
      rx_ff <= rx_in;  rz_ff <= rz_in;
      fx2_ff <= fx_ff; fy2_ff <= fy_ff; fz2_ff <= fz_ff;
      rx2_ff <= rx_ff; rz2_ff <= rz_ff;
      ux_ff <= ux_in;  uy_ff <= uy_in;  uz_ff <= uz_in;
   end

   assign rt_x = rx2_ff;
   assign rt_z = rz2_ff;
   assign fw_x = fx2_ff;
   assign fw_y = fy2_ff;
   assign fw_z = fz2_ff;
   assign up_x = ux_ff;
   assign up_y = uy_ff;
   assign up_z = uz_ff;
endmodule
`default_nettype wire

// ===== rtl/ypvm_dot.sv =====
// Translation unit: saturated, rounded -dot(row, position) in Q16.16.
// Two register stages (products, then sum/round/saturate); uses ypvm_pkg.
`default_nettype none
module ypvm_dot (
   input  wire logic               clock,
   input  wire logic signed [17:0] vx,
   input  wire logic signed [17:0] vy,
   input  wire logic signed [17:0] vz,
   input  wire logic signed [31:0] px,
   input  wire logic signed [31:0] py,
   input  wire logic signed [31:0] pz,
   output logic signed [31:0]      trans
);
   localparam int F = ypvm_pkg::VecFracBits;
   logic signed [49:0] mx_ff, my_ff, mz_ff;
   logic signed [31:0] trans_ff;
   logic signed [51:0] sum, r;

   always_comb begin
      sum = -(52'(mx_ff) + 52'(my_ff) + 52'(mz_ff));
      r = (sum + (52'sd1 <<< (F - 1))) >>> F;
   end

   always_ff @(posedge clock) begin
      mx_ff <= 50'(vx) * 50'(px);
      my_ff <= 50'(vy) * 50'(py);
      mz_ff <= 50'(vz) * 50'(pz);
      if (r > 52'sd2147483647) trans_ff <= 32'sh7fffffff;
      else if (r < -52'sd2147483648) trans_ff <= 32'sh80000000;
      else trans_ff <= r[31:0];
   end

   assign trans = trans_ff;
endmodule
`default_nettype wire

// ===== rtl/yaw_pitch_view_matrix.sv =====
// Top level of the yaw/pitch view-matrix pipeline.
// Depends on ypvm_pkg, ypvm_sin, ypvm_basis and ypvm_dot.
`default_nettype none
// Pipeline: ten register stages; rsp_valid rises as the request leaves the last
// of them, together with the response data in the output register.
// Throughput: one request per cycle; busy is tied low since the receiver
// cannot stall and every stage simply advances each cycle.
// Reset (synchronous, active high) clears only the valid pipeline; payload
// registers run free and carry no meaning while their valid bit is low.
module yaw_pitch_view_matrix (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ypvm_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ypvm_pkg::rsp_type      rsp_data
);
   // Sine stage 5, basis stage 2, translations stage 2, then an output register.
   localparam int SinLat   = 5;
   localparam int BasisLat = 2;
   localparam int Lat      = SinLat + BasisLat + 3;
   localparam int PosLat   = SinLat + BasisLat;

   logic [Lat-1:0] valid_ff;
   logic [ypvm_pkg::AngleBits-1:0] yaw, pitch, quarter;
   logic signed [17:0] sy, cy, sp, cp;
   logic signed [17:0] rt_x, rt_z, up_x, up_y, up_z, fw_x, fw_y, fw_z;
   logic signed [31:0] px_ff [PosLat], py_ff [PosLat], pz_ff [PosLat];
   logic signed [17:0] rx_d_ff [2], rz_d_ff [2], ux_d_ff [2], uy_d_ff [2];
   logic signed [17:0] uz_d_ff [2], fx_d_ff [2], fy_d_ff [2], fz_d_ff [2];
   logic signed [31:0] tr, tu, tf;
   ypvm_pkg::rsp_type rsp_ff;
   ypvm_pkg::rsp_type rsp_in;

   assign busy = 1'b0;
   assign quarter = ypvm_pkg::AngleBits'(1) << ypvm_pkg::QBits;
   assign yaw   = req_data.yaw_angle[ypvm_pkg::AngleBits-1:0];
   assign pitch = req_data.pitch_angle[ypvm_pkg::AngleBits-1:0];

   ypvm_sin u_sy (.clock(clock), .angle(yaw),             .sine(sy));
   ypvm_sin u_cy (.clock(clock), .angle(yaw + quarter),   .sine(cy));
   ypvm_sin u_sp (.clock(clock), .angle(pitch),           .sine(sp));
   ypvm_sin u_cp (.clock(clock), .angle(pitch + quarter), .sine(cp));

   ypvm_basis u_basis (
      .clock(clock), .sy(sy), .cy(cy), .sp(sp), .cp(cp),
      .rt_x(rt_x), .rt_z(rt_z), .up_x(up_x), .up_y(up_y), .up_z(up_z),
      .fw_x(fw_x), .fw_y(fw_y), .fw_z(fw_z)
   );

   // Positions travel alongside the angle pipeline to meet the basis rows.
   always_ff @(posedge clock) begin
      px_ff[0] <= req_data.pos_x;
      py_ff[0] <= req_data.pos_y;
      pz_ff[0] <= req_data.pos_z;
      for (int i = 1; i < PosLat; i++) begin
         px_ff[i] <= px_ff[i-1];
         py_ff[i] <= py_ff[i-1];
         pz_ff[i] <= pz_ff[i-1];
      end
   end

   ypvm_dot u_tr (.clock(clock), .vx(rt_x), .vy(18'sd0), .vz(rt_z),
      .px(px_ff[PosLat-1]), .py(py_ff[PosLat-1]), .pz(pz_ff[PosLat-1]), .trans(tr));
   ypvm_dot u_tu (.clock(clock), .vx(up_x), .vy(up_y), .vz(up_z),
      .px(px_ff[PosLat-1]), .py(py_ff[PosLat-1]), .pz(pz_ff[PosLat-1]), .trans(tu));
   ypvm_dot u_tf (.clock(clock), .vx(fw_x), .vy(fw_y), .vz(fw_z),
      .px(px_ff[PosLat-1]), .py(py_ff[PosLat-1]), .pz(pz_ff[PosLat-1]), .trans(tf));

   // Basis vectors pass through two delay registers to meet the translations.
   always_ff @(posedge clock) begin
      rx_d_ff[0] <= rt_x; rz_d_ff[0] <= rt_z;
      ux_d_ff[0] <= up_x; uy_d_ff[0] <= up_y; uz_d_ff[0] <= up_z;
      fx_d_ff[0] <= fw_x; fy_d_ff[0] <= fw_y; fz_d_ff[0] <= fw_z;
      rx_d_ff[1] <= rx_d_ff[0]; rz_d_ff[1] <= rz_d_ff[0];
      ux_d_ff[1] <= ux_d_ff[0]; uy_d_ff[1] <= uy_d_ff[0]; uz_d_ff[1] <= uz_d_ff[0];
      fx_d_ff[1] <= fx_d_ff[0]; fy_d_ff[1] <= fy_d_ff[0]; fz_d_ff[1] <= fz_d_ff[0];
   end

   always_comb begin
      rsp_in.right_x     = rx_d_ff[1][15:0];
      rsp_in.right_y     = '0;
      rsp_in.right_z     = rz_d_ff[1][15:0];
      rsp_in.up_x        = ux_d_ff[1][15:0];
      rsp_in.up_y        = uy_d_ff[1][15:0];
      rsp_in.up_z        = uz_d_ff[1][15:0];
      rsp_in.fwd_x       = fx_d_ff[1][15:0];
      rsp_in.fwd_y       = fy_d_ff[1][15:0];
      rsp_in.fwd_z       = fz_d_ff[1][15:0];
      rsp_in.trans_right = tr;
      rsp_in.trans_up    = tu;
      rsp_in.trans_fwd   = tf;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Lat-2:0], start & ~busy};
      end
   end

   assign rsp_valid = valid_ff[Lat-1];
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== tb/tb_yaw_pitch_view_matrix.sv =====
// Self-checking bench for the yaw/pitch view-matrix pipeline: drives camera
// poses, predicts the basis rows and translations, and checks each response.
// Depends on ypvm_pkg and yaw_pitch_view_matrix.
`default_nettype none
module tb_yaw_pitch_view_matrix;

   localparam int Latency = 10;
   localparam longint One = 64'sd1 <<< ypvm_pkg::VecFracBits;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ypvm_pkg::req_type req_data = '0;
   logic rsp_valid;
   ypvm_pkg::rsp_type rsp_data;

   ypvm_pkg::req_type pose_queue[$];
   ypvm_pkg::rsp_type view_queue[$];
   int mismatch_count = 0;
   int response_count = 0;
   int pose_count = 0;
   bit hold_sender = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   yaw_pitch_view_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Rounding of a product by n bits, half-up toward +infinity on ties.
   // The arithmetic shift of a signed value is already a floor.
   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp_one(longint v);
      if (v > One) return One;
      if (v < -One) return -One;
      return v;
   endfunction

   // Quarter-wave polynomial sine; the result is in Q2.14.
   function automatic longint quarter_sine(logic [ypvm_pkg::AngleBits-1:0] ang);
      logic [1:0] quad;
      logic [ypvm_pkg::QBits-1:0] frac;
      longint unsigned t, x, x2, t1, t2, s;
      longint v;
      quad = ang[ypvm_pkg::AngleBits-1 -: 2];
      frac = ang[ypvm_pkg::QBits-1:0];
      t = quad[0] ? ((64'd1 << ypvm_pkg::QBits) - frac) : frac;
      x = t << ypvm_pkg::PolyShift;
      x2 = (x * x) >> 30;
      t1 = ypvm_pkg::PolyB - ((ypvm_pkg::PolyC * x2) >> 30);
      t2 = ypvm_pkg::PolyA - ((x2 * t1) >> 30);
      s = (x * t2) >> 30;
      s = (s + (64'd1 << (29 - ypvm_pkg::VecFracBits))) >> (30 - ypvm_pkg::VecFracBits);
      v = longint'(s);
      if (v > One) v = One;
      return quad[1] ? -v : v;
   endfunction

   // Negated dot product of a basis row with the position, saturated.
   function automatic logic signed [31:0] neg_dot(longint a, longint b, longint c,
                                                 ypvm_pkg::req_type p);
      longint sum, r;
      sum = a * longint'(p.pos_x) + b * longint'(p.pos_y) + c * longint'(p.pos_z);
      r = round_shift(-sum, ypvm_pkg::VecFracBits);
      if (r > 64'sd2147483647) return 32'sh7fffffff;
      if (r < -64'sd2147483648) return 32'sh80000000;
      return r[31:0];
   endfunction

   function automatic ypvm_pkg::rsp_type view_rows(ypvm_pkg::req_type p);
      ypvm_pkg::rsp_type r;
      longint sy, cy, sp, cp, fx, fy, fz, rx, rz, ux, uy, uz;
      logic [15:0] yaw, pitch, quarter;
      yaw = p.yaw_angle;
      pitch = p.pitch_angle;
      quarter = 16'd1 << ypvm_pkg::QBits;
      sy = quarter_sine(yaw);
      cy = quarter_sine(yaw + quarter);
      sp = quarter_sine(pitch);
      cp = quarter_sine(pitch + quarter);
      fx = -round_shift(sy * cp, ypvm_pkg::VecFracBits);
      fy = -sp;
      fz = -round_shift(cy * cp, ypvm_pkg::VecFracBits);
      // Right flips with the sign of cos pitch; straight up or down it is +x.
      if (cp > 0) begin
         rx = cy; rz = -sy;
      end else if (cp < 0) begin
         rx = -cy; rz = sy;
      end else begin
         rx = One; rz = 0;
      end
      ux = clamp_one(round_shift(-rz * fy, ypvm_pkg::VecFracBits));
      uy = clamp_one(round_shift(rz * fx - rx * fz, ypvm_pkg::VecFracBits));
      uz = clamp_one(round_shift(rx * fy, ypvm_pkg::VecFracBits));
      r.right_x = rx[15:0]; r.right_y = '0; r.right_z = rz[15:0];
      r.up_x = ux[15:0]; r.up_y = uy[15:0]; r.up_z = uz[15:0];
      r.fwd_x = fx[15:0]; r.fwd_y = fy[15:0]; r.fwd_z = fz[15:0];
      r.trans_right = neg_dot(rx, 0, rz, p);
      r.trans_up = neg_dot(ux, uy, uz, p);
      r.trans_fwd = neg_dot(fx, fy, fz, p);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0d] response %0d field %s: got %0d, expected %0d",
               $time, response_count, field, got, want);
      mismatch_count++;
   endtask

   function automatic logic [31:0] any_position();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic ypvm_pkg::req_type random_pose();
      ypvm_pkg::req_type p;
      p.yaw_angle = 16'($urandom);
      case ($urandom_range(0, 7))
         0: p.pitch_angle = 16'sd16384;
         1: p.pitch_angle = -16'sd16384;
         2: p.pitch_angle = 16'($urandom);   // full 16-bit range, wrapping past vertical
         default: p.pitch_angle = 16'($urandom_range(0, 32768) - 16384);
      endcase
      p.pos_x = any_position();
      p.pos_y = any_position();
      p.pos_z = any_position();
      return p;
   endfunction

   // Driver: bursts of back-to-back requests with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) void'(pose_queue.pop_front());
         if (hold_sender || pose_queue.size() == 0) begin
            start <= 1'b0;
         end else if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else begin
            // The head of the queue, after any pop above, is the next request.
            if (start && !busy && pose_queue.size() == 0) begin
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_data <= pose_queue[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         if (start && !busy) begin
            view_queue.push_back(view_rows(req_data));
            pose_count++;
         end
      end
   end

   // Monitor: every strobe is one response, compared with the oldest prediction.
   always @(posedge clock) begin
      ypvm_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         response_count++;
         if (view_queue.size() == 0) begin
            $display("[%0d] response with no request outstanding", $time);
            mismatch_count++;
         end else begin
            want = view_queue.pop_front();
            if (rsp_data.right_x !== want.right_x)
               report_mismatch("right_x", rsp_data.right_x, want.right_x);
            if (rsp_data.right_y !== want.right_y)
               report_mismatch("right_y", rsp_data.right_y, want.right_y);
            if (rsp_data.right_z !== want.right_z)
               report_mismatch("right_z", rsp_data.right_z, want.right_z);
            if (rsp_data.up_x !== want.up_x)
               report_mismatch("up_x", rsp_data.up_x, want.up_x);
            if (rsp_data.up_y !== want.up_y)
               report_mismatch("up_y", rsp_data.up_y, want.up_y);
            if (rsp_data.up_z !== want.up_z)
               report_mismatch("up_z", rsp_data.up_z, want.up_z);
            if (rsp_data.fwd_x !== want.fwd_x)
               report_mismatch("fwd_x", rsp_data.fwd_x, want.fwd_x);
            if (rsp_data.fwd_y !== want.fwd_y)
               report_mismatch("fwd_y", rsp_data.fwd_y, want.fwd_y);
            if (rsp_data.fwd_z !== want.fwd_z)
               report_mismatch("fwd_z", rsp_data.fwd_z, want.fwd_z);
            if (rsp_data.trans_right !== want.trans_right)
               report_mismatch("trans_right", rsp_data.trans_right, want.trans_right);
            if (rsp_data.trans_up !== want.trans_up)
               report_mismatch("trans_up", rsp_data.trans_up, want.trans_up);
            if (rsp_data.trans_fwd !== want.trans_fwd)
               report_mismatch("trans_fwd", rsp_data.trans_fwd, want.trans_fwd);
         end
      end
   end

   // Stimulus: directed poses first, then random ones with a full drain halfway.
   initial begin
      ypvm_pkg::req_type p;
      int idx;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Cardinal yaws and the edge yaws, level pitch and a small position.
      for (idx = 0; idx < 7; idx++) begin
         p = '0;
         p.yaw_angle = 16'((idx == 6) ? 16'hffff : (idx == 5) ? 16'h0001 : idx * 16'h4000);
         p.pos_x = 32'sh00010000; p.pos_y = -32'sh00020000; p.pos_z = 32'sh00030000;
         pose_queue.push_back(p);
      end
      // Straight up and straight down, where right falls back to +x.
      p = '0; p.yaw_angle = 16'h1234; p.pitch_angle = 16'sd16384;
      p.pos_x = 32'sh7fffffff; pose_queue.push_back(p);
      p.pitch_angle = -16'sd16384; p.pos_x = 32'sh80000000; pose_queue.push_back(p);
      // Pitch wrapping past vertical, including the 16-bit extremes, then just below level.
      p = '0; p.yaw_angle = 16'h3000; p.pitch_angle = 16'sh7fff; pose_queue.push_back(p);
      p.pitch_angle = 16'sh8000; pose_queue.push_back(p);
      p.pitch_angle = 16'sd20000; pose_queue.push_back(p);
      p.pitch_angle = -16'sd1; pose_queue.push_back(p);
      // Translation saturation in both directions, all bits of positions set.
      p = '0; p.yaw_angle = 16'h2000; p.pitch_angle = 16'sd4096;
      p.pos_x = 32'sh7fffffff; p.pos_y = 32'sh7fffffff; p.pos_z = 32'sh7fffffff;
      pose_queue.push_back(p);
      p.pos_x = 32'sh80000000; p.pos_y = 32'sh80000000; p.pos_z = 32'sh80000000;
      pose_queue.push_back(p);
      p.yaw_angle = 16'ha000; p.pitch_angle = -16'sd4096; pose_queue.push_back(p);
      p.pos_x = -32'sd1; p.pos_y = -32'sd1; p.pos_z = -32'sd1; pose_queue.push_back(p);

      for (idx = 0; idx < 270; idx++) pose_queue.push_back(random_pose());
      wait (pose_queue.size() == 0 && !start);
      // Hold the sender until the pipeline has drained completely.
      hold_sender = 1'b1;
      wait (view_queue.size() == 0);
      @(posedge clock);
      hold_sender = 1'b0;
      for (idx = 0; idx < 265; idx++) pose_queue.push_back(random_pose());
      wait (pose_queue.size() == 0 && !start);
      wait (view_queue.size() == 0);
      repeat (Latency + 4) @(posedge clock);
      $display("Sent %0d camera poses and checked %0d view matrices.",
               pose_count, response_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d field mismatches.", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Timed out with %0d responses outstanding.", view_queue.size());
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
